### sv/md5sh_pkg.sv
// Package: shared types and constants for the MD5 stream hash.
package md5sh_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       end_of_message;
   } md5sh_req_type;

   typedef struct packed {
      logic [31:0] digest_a;
      logic [31:0] digest_b;
      logic [31:0] digest_c;
      logic [31:0] digest_d;
   } md5sh_rsp_type;

   // Queue entry from the front end to the compression engine.
   typedef struct packed {
      logic         last;       // finishing block: emit digest, reload IV
      logic [511:0] block;      // 64 bytes, byte 0 in bits [7:0]
   } md5sh_blk_type;

   typedef enum logic [1:0] {
      FE_COLLECT,
      FE_PAD,
      FE_LEN
   } md5sh_fe_state_type;

   typedef enum logic [1:0] {
      BE_IDLE,
      BE_ROUND,
      BE_ADD
   } md5sh_be_state_type;

   localparam logic [31:0] IV_A = 32'h67452301;
   localparam logic [31:0] IV_B = 32'hefcdab89;
   localparam logic [31:0] IV_C = 32'h98badcfe;
   localparam logic [31:0] IV_D = 32'h10325476;
   localparam logic [7:0]  PAD_BYTE = 8'h80;

   function automatic logic [31:0] round_const(input logic [5:0] i);
      logic [31:0] k;
      case (i)
         6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;  6'd2: k = 32'h242070db;
         6'd3: k = 32'hc1bdceee;  6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
         6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;  6'd8: k = 32'h698098d8;
         6'd9: k = 32'h8b44f7af;  6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
         6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
         6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
         6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
         6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
         6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
         6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
         6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
         6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
         6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
         6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
         6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
         6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
         6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
         6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
         6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
         6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
         6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
         6'd63: k = 32'heb86d391;
         default: k = 32'h0;
      endcase
      return k;
   endfunction

   function automatic logic [4:0] rot_amount(input logic [5:0] i);
      logic [4:0] s;
      case ({i[5:4], i[1:0]})
         4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
         4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
         4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
         4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
         default: s = 5'd0;
      endcase
      return s;
   endfunction

   // Message word index for round i.
   function automatic logic [3:0] word_index(input logic [5:0] i);
      logic [3:0] g;
      case (i[5:4])
         2'd0: g = i[3:0];
         2'd1: g = 4'(5 * i[3:0] + 1);
         2'd2: g = 4'(3 * i[3:0] + 5);
         default: g = 4'(7 * i[3:0]);
      endcase
      return g;
   endfunction

endpackage

### sv/md5_stream_hash.sv
// MD5 stream hash: byte front end, block queue, round-serial compression engine.
// Throughput: one byte per cycle while the queue has room, pausing after each full
// block until it is handed on; the single round unit takes no new block until done.
// The digest follows the last beat once its final block, or both blocks when padding
// spills over, has left the engine; later if earlier blocks queue or the digest waits.
// Reset: synchronous, active high; chaining words return to the MD5 initial vector.
module md5_stream_hash import md5sh_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  md5sh_req_type req_data,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output md5sh_rsp_type rsp_data
);

   logic          f_valid, f_ready, e_valid, e_ready;
   md5sh_blk_type f_data, e_data;

   md5sh_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .blk_valid(f_valid), .blk_ready(f_ready), .blk_data(f_data)
   );

   md5sh_queue u_queue (
      .clock, .reset,
      .in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
      .out_valid(e_valid), .out_ready(e_ready), .out_data(e_data)
   );

   md5sh_engine u_engine (
      .clock, .reset,
      .blk_valid(e_valid), .blk_ready(e_ready), .blk_data(e_data),
      .rsp_valid, .rsp_ready, .rsp_data
   );

endmodule

### sv/md5sh_front.sv
// Front end: collect bytes into blocks, append padding and length.
module md5sh_front import md5sh_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  md5sh_req_type req_data,
   output logic          blk_valid,
   input  logic          blk_ready,
   output md5sh_blk_type blk_data
);

   md5sh_fe_state_type state_ff, state_in;
   logic [511:0] block_ff, block_in;
   logic [60:0]  count_ff, count_in;
   logic [5:0]   pos_ff, pos_in;     // next byte slot
   logic         blk_valid_ff, blk_valid_in;
   logic         blk_last_ff, blk_last_in;
   logic [63:0]  bit_len;

   assign bit_len   = {count_ff, 3'b000};
   assign req_ready = (state_ff == FE_COLLECT) && !blk_valid_ff;
   assign blk_valid = blk_valid_ff;
   assign blk_data  = '{last: blk_last_ff, block: block_ff};

   // Place bytes, issue full blocks, then pad and append the length.
   always_comb begin
      state_in     = state_ff;
      block_in     = block_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      blk_valid_in = blk_valid_ff;
      blk_last_in  = blk_last_ff;
      if (blk_valid_ff && blk_ready) begin
         blk_valid_in = 1'b0;
      end
      case (state_ff)
         FE_COLLECT: begin
            if (req_valid && req_ready) begin
               if (req_data.has_byte) begin
                  block_in[pos_ff*8 +: 8] = req_data.data_byte;
                  count_in = count_ff + 61'd1;
                  pos_in   = pos_ff + 6'd1;
                  if (pos_ff == 6'd63) begin
                     blk_valid_in = 1'b1;
                     blk_last_in  = 1'b0;
                  end
               end
               if (req_data.end_of_message) begin
                  state_in = FE_PAD;
               end
            end
         end
         FE_PAD: begin
            if (!blk_valid_ff) begin
               block_in[pos_ff*8 +: 8] = PAD_BYTE;
               for (int j = 0; j < 64; j++) begin
                  if (j > pos_ff) block_in[j*8 +: 8] = 8'h00;
               end
               if (pos_ff > 6'd55) begin
                  blk_valid_in = 1'b1;
                  blk_last_in  = 1'b0;
                  pos_in       = 6'd0;
                  state_in     = FE_LEN;
               end else begin
                  block_in[511:448] = bit_len;
                  blk_valid_in = 1'b1;
                  blk_last_in  = 1'b1;
                  pos_in       = 6'd0;
                  count_in     = '0;
                  state_in     = FE_COLLECT;
               end
            end
         end
         FE_LEN: begin
            if (!blk_valid_ff) begin
               block_in = {bit_len, 448'd0};
               blk_valid_in = 1'b1;
               blk_last_in  = 1'b1;
               count_in     = '0;
               state_in     = FE_COLLECT;
            end
         end
         default: state_in = FE_COLLECT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FE_COLLECT;
         count_ff     <= '0;
         pos_ff       <= '0;
         blk_valid_ff <= 1'b0;
         blk_last_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         blk_valid_ff <= blk_valid_in;
         blk_last_ff  <= blk_last_in;
      end
      block_ff <= block_in;
   end

   // Byte slot follows the count.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == FE_COLLECT) |-> (pos_ff == count_ff[5:0]))
      else $error("slot and count disagree");
   // Padding never starts over an unsent block.
   assert property (@(posedge clock) disable iff (reset)
      (blk_valid_ff && !blk_ready) |=> blk_valid_ff && $stable(blk_last_ff))
      else $error("block dropped");
   assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !blk_valid_ff)
      else $error("accepting while block pending");

endmodule

### sv/md5sh_queue.sv
// Two-entry queue of blocks between front end and compression engine.
module md5sh_queue import md5sh_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  md5sh_blk_type in_data,
   output logic          out_valid,
   input  logic          out_ready,
   output md5sh_blk_type out_data
);

   md5sh_blk_type slot_ff [2];
   logic       wptr_ff, rptr_ff;
   logic [1:0] fill_ff;
   logic       push, pop;

   assign in_ready  = (fill_ff != 2'd2);
   assign out_valid = (fill_ff != 2'd0);
   assign out_data  = slot_ff[rptr_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   // Advance pointers and fill level.
   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         if (push) wptr_ff <= ~wptr_ff;
         if (pop)  rptr_ff <= ~rptr_ff;
         fill_ff <= fill_ff + 2'(push) - 2'(pop);
      end
      if (push) slot_ff[wptr_ff] <= in_data;
   end

   assert property (@(posedge clock) disable iff (reset) fill_ff != 2'd3)
      else $error("queue overflow");
   assert property (@(posedge clock) disable iff (reset)
      (fill_ff == 2'd2) |-> (wptr_ff == rptr_ff))
      else $error("pointer mismatch when full");
   assert property (@(posedge clock) disable iff (reset)
      (fill_ff == 2'd0) |-> (wptr_ff == rptr_ff))
      else $error("pointer mismatch when empty");

endmodule

### sv/md5sh_engine.sv
// Engine: one MD5 round per cycle in BE_ROUND, digest output register.
module md5sh_engine import md5sh_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          blk_valid,
   output logic          blk_ready,
   input  md5sh_blk_type blk_data,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output md5sh_rsp_type rsp_data
);

   md5sh_be_state_type state_ff, state_in;
   logic [31:0]  ch_ff [4];
   logic [31:0]  a_ff, b_ff, c_ff, d_ff;
   logic [511:0] w_ff;
   logic         last_ff;
   logic [5:0]   rnd_ff;
   logic         rsp_valid_ff;
   md5sh_rsp_type rsp_ff;
   logic [31:0]  f, sum, rot, wg;
   logic [31:0]  na, nb, nc, nd;
   logic [4:0]   s;

   // A new block starts only when the digest register is free.
   assign blk_ready = (state_ff == BE_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // One round.
   always_comb begin
      case (rnd_ff[5:4])
         2'd0: f = (b_ff & c_ff) | (~b_ff & d_ff);
         2'd1: f = (d_ff & b_ff) | (~d_ff & c_ff);
         2'd2: f = b_ff ^ c_ff ^ d_ff;
         default: f = c_ff ^ (b_ff | ~d_ff);
      endcase
      wg  = w_ff[word_index(rnd_ff)*32 +: 32];
      sum = a_ff + f + wg + round_const(rnd_ff);
      s   = rot_amount(rnd_ff);
      rot = (sum << s) | (sum >> (6'd32 - {1'b0, s}));
   end

   assign na = ch_ff[0] + a_ff;
   assign nb = ch_ff[1] + b_ff;
   assign nc = ch_ff[2] + c_ff;
   assign nd = ch_ff[3] + d_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BE_IDLE:  if (blk_valid && blk_ready) state_in = BE_ROUND;
         BE_ROUND: if (rnd_ff == 6'd63) state_in = BE_ADD;
         BE_ADD:   state_in = BE_IDLE;
         default:  state_in = BE_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BE_IDLE;
         rsp_valid_ff <= 1'b0;
         ch_ff[0] <= IV_A; ch_ff[1] <= IV_B; ch_ff[2] <= IV_C; ch_ff[3] <= IV_D;
         rnd_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            BE_IDLE: begin
               if (blk_valid && blk_ready) begin
                  rnd_ff <= '0;
               end
            end
            BE_ROUND: rnd_ff <= rnd_ff + 6'd1;
            BE_ADD: begin
               // Fold the block in; on the last block emit and reload the IV.
               if (last_ff) begin
                  rsp_valid_ff <= 1'b1;
                  ch_ff[0] <= IV_A; ch_ff[1] <= IV_B;
                  ch_ff[2] <= IV_C; ch_ff[3] <= IV_D;
               end else begin
                  ch_ff[0] <= na; ch_ff[1] <= nb; ch_ff[2] <= nc; ch_ff[3] <= nd;
               end
            end
            default: ;
         endcase
      end
      // Working registers and payload.
      if (state_ff == BE_IDLE && blk_valid && blk_ready) begin
         w_ff    <= blk_data.block;
         last_ff <= blk_data.last;
         a_ff <= ch_ff[0]; b_ff <= ch_ff[1]; c_ff <= ch_ff[2]; d_ff <= ch_ff[3];
      end else if (state_ff == BE_ROUND) begin
         a_ff <= d_ff;
         d_ff <= c_ff;
         c_ff <= b_ff;
         b_ff <= b_ff + rot;
      end
      if (state_ff == BE_ADD && last_ff && !reset) begin
         rsp_ff <= '{digest_a: na, digest_b: nb, digest_c: nc, digest_d: nd};
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == BE_ADD) |-> !rsp_valid_ff)
      else $error("digest overwritten");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == BE_ROUND && rnd_ff == 6'd63) |=> (state_ff == BE_ADD))
      else $error("round count broken");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == BE_IDLE) |-> (rnd_ff == 6'd0 || rnd_ff == 6'd63 || $past(reset)
         || rnd_ff == 6'd0))
      else $error("stray round counter");

endmodule
